@@ rtl/ftwa_pkg.sv @@
// shared types and constants for the flow table with aging
package ftwa_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ACTIVE_W      = 7;
    localparam logic [31:0] INACT_RESET = 32'd180;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_FIND    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_EXPIRE  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_RESP,
        S_OUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EMIT_SEL,
        S_EMIT_LD,
        S_EMIT_OUT
    } ftwa_state_t;

    typedef struct packed {
        logic cap;
        logic look;
        logic exec;
        logic resp;
        logic scan_start;
        logic scan_rd;
        logic scan_cmp;
        logic emit_rd;
        logic emit_ld;
    } ftwa_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       scan_end;
        logic       any_mark;
    } ftwa_sts_t;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] handle;
        logic [31:0] ftime;
    } ftwa_entry_t;

endpackage

@@ rtl/ftwa_ctrl.sv @@
// request sequencer for the flow table
module ftwa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ftwa_pkg::ftwa_sts_t sts,
    output ftwa_pkg::ftwa_cmd_t cmd
);

    ftwa_pkg::ftwa_state_t state_reg;
    ftwa_pkg::ftwa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftwa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ftwa_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ftwa_pkg::S_LOOK;
                end
            end
            ftwa_pkg::S_LOOK:
            begin
                if (sts.action == ftwa_pkg::ACT_EXPIRE)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ftwa_pkg::S_SCAN_RD;
                end
                else
                begin
                    cmd.look   = 1'b1;
                    state_next = ftwa_pkg::S_EXEC;
                end
            end
            ftwa_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.action == ftwa_pkg::ACT_INSERT)
                begin
                    state_next = ftwa_pkg::S_OUT;
                end
                else
                begin
                    state_next = ftwa_pkg::S_RESP;
                end
            end
            ftwa_pkg::S_RESP:
            begin
                cmd.resp   = 1'b1;
                state_next = ftwa_pkg::S_OUT;
            end
            ftwa_pkg::S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ftwa_pkg::S_IDLE;
                end
            end
            ftwa_pkg::S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ftwa_pkg::S_SCAN_CMP;
            end
            ftwa_pkg::S_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ftwa_pkg::S_EMIT_SEL;
                end
                else
                begin
                    state_next = ftwa_pkg::S_SCAN_RD;
                end
            end
            ftwa_pkg::S_EMIT_SEL:
            begin
                if (sts.any_mark)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ftwa_pkg::S_EMIT_LD;
                end
                else
                begin
                    state_next = ftwa_pkg::S_IDLE;
                end
            end
            ftwa_pkg::S_EMIT_LD:
            begin
                cmd.emit_ld = 1'b1;
                state_next  = ftwa_pkg::S_EMIT_OUT;
            end
            ftwa_pkg::S_EMIT_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ftwa_pkg::S_EMIT_SEL;
                end
            end
            default:
            begin
                state_next = ftwa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ftwa_datapath.sv @@
// flow table storage, key match, aging scan and counters
module ftwa_datapath
#(
    parameter int TABLE_DEPTH = ftwa_pkg::DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ftwa_pkg::ftwa_cmd_t               cmd,
    output ftwa_pkg::ftwa_sts_t               sts,
    input  logic                              cfg_we,
    input  logic [31:0]                       cfg_wdata,
    input  logic [1:0]                        in_action,
    input  logic [31:0]                       in_key,
    input  logic [15:0]                       in_handle,
    input  logic [31:0]                       in_ftime,
    input  logic [31:0]                       in_now,
    output logic [1:0]                        out_status,
    output logic [15:0]                       out_handle,
    output logic [31:0]                       out_key,
    output logic                              out_expired,
    output logic                              out_last,
    output logic [ftwa_pkg::ACTIVE_W-1:0]     active_flows,
    output logic [31:0]                       total_inserts,
    output logic [31:0]                       total_releases,
    output logic [31:0]                       total_expires
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // control state
    logic [31:0]                   inact_reg;
    logic [TABLE_DEPTH-1:0]        valid_reg;
    logic [TABLE_DEPTH-1:0]        mark_reg;
    logic [ftwa_pkg::ACTIVE_W-1:0] active_reg;
    logic [31:0]                   ins_cnt_reg;
    logic [31:0]                   rel_cnt_reg;
    logic [31:0]                   exp_cnt_reg;

    // payload
    logic [1:0]           action_reg;
    logic [31:0]          key_reg;
    logic [15:0]          handle_reg;
    logic [31:0]          ftime_reg;
    logic [31:0]          now_reg;
    logic                 hit_reg;
    logic [IW-1:0]        idx_reg;
    logic                 free_ok_reg;
    logic [IW-1:0]        free_idx_reg;
    logic [IW-1:0]        scan_idx_reg;
    logic [IW-1:0]        emit_idx_reg;
    logic [31:0]          ckey_reg [TABLE_DEPTH];
    ftwa_pkg::ftwa_entry_t mem [TABLE_DEPTH];
    ftwa_pkg::ftwa_entry_t rdata_reg;

    logic [1:0]  ostat_reg;
    logic [15:0] ohandle_reg;
    logic [31:0] okey_reg;
    logic        oexp_reg;
    logic        olast_reg;

    // lookup and selection
    logic                   hit;
    logic [IW-1:0]          hit_idx;
    logic                   free_ok;
    logic [IW-1:0]          free_idx;
    logic [IW-1:0]          mark_idx;
    logic [TABLE_DEPTH-1:0] mark_rest;
    logic [IW-1:0]          rd_addr;
    logic                   rd_en;
    logic                   ins_wr;
    logic [IW-1:0]          wr_addr;
    logic                   aged;
    logic [32:0]            age_sum;

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        mark_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (ckey_reg[i] == key_reg))
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
            if (mark_reg[i])
            begin
                mark_idx = IW'(i);
            end
        end
    end

    assign mark_rest = mark_reg & ~(TABLE_DEPTH'(1) << emit_idx_reg);

    assign age_sum = {1'b0, rdata_reg.ftime} + {1'b0, inact_reg};
    assign aged    = valid_reg[scan_idx_reg] && (age_sum <= {1'b0, now_reg});

    assign ins_wr  = cmd.exec && (action_reg == ftwa_pkg::ACT_INSERT) && (hit_reg || free_ok_reg);
    assign wr_addr = hit_reg ? idx_reg : free_idx_reg;

    always_comb
    begin
        rd_addr = idx_reg;
        if (cmd.scan_rd)
        begin
            rd_addr = scan_idx_reg;
        end
        else if (cmd.emit_rd)
        begin
            rd_addr = mark_idx;
        end
    end

    assign rd_en = cmd.exec || cmd.scan_rd || cmd.emit_rd;

    // entry memory
    always_ff @(posedge clk)
    begin
        if (ins_wr)
        begin
            mem[wr_addr]      <= '{key: key_reg, handle: handle_reg, ftime: ftime_reg};
            ckey_reg[wr_addr] <= key_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inact_reg   <= ftwa_pkg::INACT_RESET;
            valid_reg   <= '0;
            mark_reg    <= '0;
            active_reg  <= '0;
            ins_cnt_reg <= '0;
            rel_cnt_reg <= '0;
            exp_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                inact_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                if (action_reg == ftwa_pkg::ACT_INSERT)
                begin
                    if (hit_reg)
                    begin
                        ins_cnt_reg <= ins_cnt_reg + 32'd1;
                    end
                    else if (free_ok_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        active_reg              <= active_reg + 1'b1;
                        ins_cnt_reg             <= ins_cnt_reg + 32'd1;
                    end
                end
                else if ((action_reg == ftwa_pkg::ACT_RELEASE) && hit_reg)
                begin
                    valid_reg[idx_reg] <= 1'b0;
                    active_reg         <= active_reg - 1'b1;
                    rel_cnt_reg        <= rel_cnt_reg + 32'd1;
                end
            end
            if (cmd.scan_start)
            begin
                mark_reg <= '0;
            end
            if (cmd.scan_cmp && aged)
            begin
                mark_reg[scan_idx_reg]  <= 1'b1;
                valid_reg[scan_idx_reg] <= 1'b0;
                active_reg              <= active_reg - 1'b1;
                rel_cnt_reg             <= rel_cnt_reg + 32'd1;
                exp_cnt_reg             <= exp_cnt_reg + 32'd1;
            end
            if (cmd.emit_ld)
            begin
                mark_reg <= mark_rest;
            end
        end
    end

    // request capture, lookup results and result register
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            action_reg <= in_action;
            key_reg    <= in_key;
            handle_reg <= in_handle;
            ftime_reg  <= in_ftime;
            now_reg    <= in_now;
        end
        if (cmd.look)
        begin
            hit_reg      <= hit;
            idx_reg      <= hit_idx;
            free_ok_reg  <= free_ok;
            free_idx_reg <= free_idx;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_cmp)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.emit_rd)
        begin
            emit_idx_reg <= mark_idx;
        end
        if (cmd.exec && (action_reg == ftwa_pkg::ACT_INSERT))
        begin
            ostat_reg   <= (hit_reg || free_ok_reg) ? ftwa_pkg::ST_OK : ftwa_pkg::ST_FULL;
            ohandle_reg <= handle_reg;
            okey_reg    <= key_reg;
            oexp_reg    <= 1'b0;
            olast_reg   <= 1'b1;
        end
        if (cmd.resp)
        begin
            ostat_reg   <= hit_reg ? ftwa_pkg::ST_OK : ftwa_pkg::ST_MISS;
            ohandle_reg <= hit_reg ? rdata_reg.handle : 16'd0;
            okey_reg    <= key_reg;
            oexp_reg    <= 1'b0;
            olast_reg   <= 1'b1;
        end
        if (cmd.emit_ld)
        begin
            ostat_reg   <= ftwa_pkg::ST_OK;
            ohandle_reg <= rdata_reg.handle;
            okey_reg    <= rdata_reg.key;
            oexp_reg    <= 1'b1;
            olast_reg   <= (mark_rest == '0);
        end
    end

    assign sts.action   = action_reg;
    assign sts.scan_end = (scan_idx_reg == IW'(TABLE_DEPTH - 1));
    assign sts.any_mark = |mark_reg;

    assign out_status     = ostat_reg;
    assign out_handle     = ohandle_reg;
    assign out_key        = okey_reg;
    assign out_expired    = oexp_reg;
    assign out_last       = olast_reg;
    assign active_flows   = active_reg;
    assign total_inserts  = ins_cnt_reg;
    assign total_releases = rel_cnt_reg;
    assign total_expires  = exp_cnt_reg;

endmodule

@@ rtl/flow_table_with_aging.sv @@
// top level of the flow table with idle-time aging
// Connection table of TABLE_DEPTH flows keyed by the XOR of the 5-tuple, so both
// directions of a flow share one entry. One request is handled at a time. An insert
// result is offered after the lookup and execute states, a find or release result
// after a further response state; the parallel key match and the registered read of
// the entry memory call for these states. An expire tick first scans every entry,
// with one memory read and one aging compare per entry, then emits one result per
// expired flow through select, load and output states, plus output stall; a tick
// that ages out nothing gives no result. Every result of a tick carries the counters
// after the whole tick, and the last one has tlast set. Valid marks clear at reset,
// no clearing pass.
module flow_table_with_aging
#(
    parameter int TABLE_DEPTH = ftwa_pkg::DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    // request side
    input  logic         s_tvalid,
    output logic         s_tready,
    // source_addr[31:0] source_port[47:32] protocol_number[63:48] dest_addr[95:64]
    // dest_port[111:96] flow_handle[127:112] flow_time[159:128] now_time[191:160]
    input  logic [191:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    // result side
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0] result_handle[17:2] flow_key[49:18] active_flows[56:50]
    // total_inserts[88:57] total_releases[120:89] total_expires[152:121], zero above
    output logic [159:0] m_tdata,
    // expired[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    // inactivity_seconds register
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    ftwa_pkg::ftwa_cmd_t cmd;
    ftwa_pkg::ftwa_sts_t sts;

    logic [31:0] in_key;
    logic [1:0]  out_status;
    logic [15:0] out_handle;
    logic [31:0] out_key;
    logic        out_expired;
    logic [ftwa_pkg::ACTIVE_W-1:0] active_flows;
    logic [31:0] total_inserts;
    logic [31:0] total_releases;
    logic [31:0] total_expires;

    // tuple key, symmetric in the two endpoints
    assign in_key = s_tdata[31:0] ^ {16'd0, s_tdata[47:32]} ^ {16'd0, s_tdata[63:48]}
                  ^ s_tdata[95:64] ^ {16'd0, s_tdata[111:96]};

    ftwa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftwa_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_action      (s_tuser),
        .in_key         (in_key),
        .in_handle      (s_tdata[127:112]),
        .in_ftime       (s_tdata[159:128]),
        .in_now         (s_tdata[191:160]),
        .out_status     (out_status),
        .out_handle     (out_handle),
        .out_key        (out_key),
        .out_expired    (out_expired),
        .out_last       (m_tlast),
        .active_flows   (active_flows),
        .total_inserts  (total_inserts),
        .total_releases (total_releases),
        .total_expires  (total_expires)
    );

    // result packing, lowest field first
    assign m_tdata = {7'd0, total_expires, total_releases, total_inserts, active_flows,
                      out_key, out_handle, out_status};
    assign m_tuser = out_expired;

endmodule

@@ rtl/ftwa_checker.sv @@
// port-level checks for the flow table, bound to the top level
module ftwa_checker
#(
    parameter int TABLE_DEPTH = ftwa_pkg::DEPTH_DEFAULT
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed under stall");

    // one request at a time: never accepting while a result is offered
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("ready while result pending");

    // the block is busy in the cycle after an accepted request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("no busy cycle after request");

    // a non-expiry result is always the only one
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("non-expiry result without last");

    // occupancy never exceeds the table size
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[56:50] <= 7'(TABLE_DEPTH))
        else $error("active flows above table depth");

endmodule

bind flow_table_with_aging ftwa_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ftwa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/tb_top.sv @@
// self-checking testbench for the flow table with aging
module tb_top;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] proto;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
        logic [15:0] handle;
        logic [31:0] ftime;
        logic [31:0] now;
    } flow_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [31:0] key;
        logic        expired;
        logic        last;
        logic [6:0]  active;
        logic [31:0] inserts;
        logic [31:0] releases;
        logic [31:0] expires;
    } flow_rsp_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;

    flow_table_with_aging #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // shadow copy of the table and its counters
    logic [31:0] timeout_s;
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_key   [DEPTH];
    logic [15:0] tbl_handle[DEPTH];
    logic [31:0] tbl_time  [DEPTH];
    logic [6:0]  n_active;
    logic [31:0] n_inserts;
    logic [31:0] n_releases;
    logic [31:0] n_expires;

    flow_req_t pending_reqs[$];
    flow_rsp_t expected_rsps[$];
    int        errors;
    int        idle_cycles;
    int        wait_div;
    bit        out_hold;
    int        out_hold_cnt;
    bit        in_pause;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] tuple_key(flow_req_t r);
        return r.src_addr ^ {16'h0, r.src_port} ^ {16'h0, r.proto} ^ r.dst_addr
               ^ {16'h0, r.dst_port};
    endfunction

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    // work out the results one request causes and queue them
    task automatic predict_request(flow_req_t r);
        logic [31:0] k;
        int          idx;
        flow_rsp_t   batch[$];
        flow_rsp_t   rsp;
        k = tuple_key(r);
        idx = find_slot(k);
        rsp = '0;
        rsp.key = k;
        case (r.action)
            ftwa_pkg::ACT_INSERT:
            begin
                rsp.handle = r.handle;
                if (idx < 0)
                begin
                    for (int i = 0; i < DEPTH; i++)
                        if (!tbl_valid[i])
                        begin
                            idx = i;
                            break;
                        end
                    if (idx >= 0)
                    begin
                        tbl_valid[idx] = 1'b1;
                        n_active++;
                    end
                end
                if (idx >= 0)
                begin
                    tbl_key[idx] = k;
                    tbl_handle[idx] = r.handle;
                    tbl_time[idx] = r.ftime;
                    n_inserts++;
                    rsp.status = ftwa_pkg::ST_OK;
                end
                else
                    rsp.status = ftwa_pkg::ST_FULL;
                batch.push_back(rsp);
            end
            ftwa_pkg::ACT_FIND, ftwa_pkg::ACT_RELEASE:
            begin
                if (idx >= 0)
                begin
                    rsp.status = ftwa_pkg::ST_OK;
                    rsp.handle = tbl_handle[idx];
                    if (r.action == ftwa_pkg::ACT_RELEASE)
                    begin
                        tbl_valid[idx] = 1'b0;
                        n_active--;
                        n_releases++;
                    end
                end
                else
                    rsp.status = ftwa_pkg::ST_MISS;
                batch.push_back(rsp);
            end
            default:
            begin
                // aging scan in index order, 33-bit sum so no wrap
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] &&
                        ({1'b0, tbl_time[i]} + {1'b0, timeout_s}) <= {1'b0, r.now})
                    begin
                        tbl_valid[i] = 1'b0;
                        n_active--;
                        n_releases++;
                        n_expires++;
                        rsp = '0;
                        rsp.status = ftwa_pkg::ST_OK;
                        rsp.handle = tbl_handle[i];
                        rsp.key = tbl_key[i];
                        rsp.expired = 1'b1;
                        batch.push_back(rsp);
                    end
            end
        endcase
        // counters after the whole step go on every result
        foreach (batch[j])
        begin
            batch[j].last = (j == batch.size() - 1);
            batch[j].active = n_active;
            batch[j].inserts = n_inserts;
            batch[j].releases = n_releases;
            batch[j].expires = n_expires;
            expected_rsps.push_back(batch[j]);
        end
    endtask

    // driver: offers pending requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            wait_div <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(pending_reqs.pop_front());
            if (s_tvalid && !s_tready)
            begin
                // hold the request until it is taken
            end
            else if (wait_div > 0)
            begin
                s_tvalid <= 1'b0;
                wait_div <= wait_div - 1;
            end
            else if (pending_reqs.size() > 0 && !in_pause)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_reqs[0].action;
                s_tdata  <= {pending_reqs[0].now, pending_reqs[0].ftime,
                             pending_reqs[0].handle, pending_reqs[0].dst_port,
                             pending_reqs[0].dst_addr, pending_reqs[0].proto,
                             pending_reqs[0].src_port, pending_reqs[0].src_addr};
                if ($urandom_range(0, 3) == 0)
                    wait_div <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side backpressure, with one forced long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_hold_cnt <= 0;
        end
        else if (out_hold)
        begin
            m_tready <= 1'b0;
            out_hold_cnt <= out_hold_cnt + 1;
        end
        else if ($urandom_range(0, 1) == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0) ? 1'b1
                        : (($urandom_range(0, 9) == 0) ? 1'b0 : 1'($urandom_range(0, 1)));
    end

    // monitor: compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            flow_rsp_t got;
            flow_rsp_t exp_r;
            got.status   = m_tdata[1:0];
            got.handle   = m_tdata[17:2];
            got.key      = m_tdata[49:18];
            got.active   = m_tdata[56:50];
            got.inserts  = m_tdata[88:57];
            got.releases = m_tdata[120:89];
            got.expires  = m_tdata[152:121];
            got.expired  = m_tuser[0];
            got.last     = m_tlast;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                             got.status);
                    errors++;
                end
                if (got.handle !== exp_r.handle)
                begin
                    $display("%0t: handle exp %h got %h", $time, exp_r.handle, got.handle);
                    errors++;
                end
                if (got.key !== exp_r.key)
                begin
                    $display("%0t: key exp %h got %h", $time, exp_r.key, got.key);
                    errors++;
                end
                if (got.expired !== exp_r.expired)
                begin
                    $display("%0t: expired exp %b got %b", $time, exp_r.expired,
                             got.expired);
                    errors++;
                end
                if (got.last !== exp_r.last)
                begin
                    $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
                    errors++;
                end
                if (got.active !== exp_r.active)
                begin
                    $display("%0t: active exp %0d got %0d", $time, exp_r.active,
                             got.active);
                    errors++;
                end
                if (got.inserts !== exp_r.inserts)
                begin
                    $display("%0t: inserts exp %h got %h", $time, exp_r.inserts,
                             got.inserts);
                    errors++;
                end
                if (got.releases !== exp_r.releases)
                begin
                    $display("%0t: releases exp %h got %h", $time, exp_r.releases,
                             got.releases);
                    errors++;
                end
                if (got.expires !== exp_r.expires)
                begin
                    $display("%0t: expires exp %h got %h", $time, exp_r.expires,
                             got.expires);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000)
            begin
                $display("FAIL flow_table_with_aging");
                $finish;
            end
        end
    end

    // random tuple from a small pool so finds and releases hit
    function automatic flow_req_t pool_req(logic [1:0] act, int id);
        flow_req_t r;
        r = '0;
        r.action = act;
        r.src_addr = 32'h0A00_0000 + id;
        r.src_port = 16'd1000 + id[15:0];
        r.proto = 16'd6;
        r.dst_addr = 32'hC0A8_0001;
        r.dst_port = 16'd80;
        r.handle = 16'($urandom);
        r.ftime = $urandom_range(0, 1000);
        r.now = $urandom_range(0, 2000);
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_tvalid)
            @(posedge clk);
        // an expire scan that ages out nothing has no result to wait for
        repeat (3 * DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_s = v;
    endtask

    initial
    begin
        flow_req_t r;
        int        id;
        errors = 0;
        in_pause = 1'b0;
        out_hold = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        timeout_s = ftwa_pkg::INACT_RESET;
        n_active = '0;
        n_inserts = '0;
        n_releases = '0;
        n_expires = '0;
        for (int i = 0; i < DEPTH; i++)
            tbl_valid[i] = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every action, miss, overwrite, swapped endpoints
        r = '0;
        r.action = ftwa_pkg::ACT_FIND;
        pending_reqs.push_back(r);
        r.action = ftwa_pkg::ACT_INSERT;
        r.handle = 16'hFFFF;
        r.ftime = 32'd100;
        pending_reqs.push_back(r);
        r = '1;
        r.action = ftwa_pkg::ACT_INSERT;
        pending_reqs.push_back(r);
        r.action = ftwa_pkg::ACT_FIND;
        pending_reqs.push_back(r);
        r = pool_req(ftwa_pkg::ACT_INSERT, 1);
        pending_reqs.push_back(r);
        r.handle = 16'h1234;
        pending_reqs.push_back(r);           // same key overwrites
        {r.src_addr, r.dst_addr} = {r.dst_addr, r.src_addr};
        {r.src_port, r.dst_port} = {r.dst_port, r.src_port};
        r.action = ftwa_pkg::ACT_FIND;
        pending_reqs.push_back(r);           // reverse direction hits
        r.action = ftwa_pkg::ACT_RELEASE;
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);           // release miss
        r = '0;
        r.action = ftwa_pkg::ACT_EXPIRE;
        r.now = 32'd279;
        pending_reqs.push_back(r);           // just short of expiry
        r.now = 32'd280;
        pending_reqs.push_back(r);           // exactly at the boundary
        r.now = 32'hFFFF_FFFF;
        pending_reqs.push_back(r);
        wait_drained();

        // largest timeout: the sum must not wrap
        write_timeout(32'hFFFF_FFFF);
        r = pool_req(ftwa_pkg::ACT_INSERT, 2);
        r.ftime = 32'd1;
        pending_reqs.push_back(r);
        r = '0;
        r.action = ftwa_pkg::ACT_EXPIRE;
        r.now = 32'hFFFF_FFFF;
        pending_reqs.push_back(r);
        wait_drained();

        // fill the table past full with the result side held off
        write_timeout(32'd0);
        out_hold = 1'b1;
        for (int i = 0; i < DEPTH + 2; i++)
            pending_reqs.push_back(pool_req(ftwa_pkg::ACT_INSERT, 100 + i));
        while (out_hold_cnt < 300)
            @(posedge clk);
        out_hold = 1'b0;
        wait_drained();
        // a full tick of expiries, many results back to back
        r = '0;
        r.action = ftwa_pkg::ACT_EXPIRE;
        r.now = 32'hFFFF_FFFF;
        pending_reqs.push_back(r);
        wait_drained();

        // random traffic over two timeouts
        write_timeout(32'd50);
        for (int n = 0; n < 70; n++)
        begin
            id = $urandom_range(0, 40);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r = pool_req(ftwa_pkg::ACT_INSERT, id);
                4, 5:       r = pool_req(ftwa_pkg::ACT_FIND, id);
                6, 7:       r = pool_req(ftwa_pkg::ACT_RELEASE, id);
                8:          r = pool_req(ftwa_pkg::ACT_EXPIRE, id);
                default:
                begin
                    r = '0;
                    r.src_addr = $urandom;
                    r.src_port = 16'($urandom);
                    r.proto = 16'($urandom);
                    r.dst_addr = $urandom;
                    r.dst_port = 16'($urandom);
                    r.handle = 16'($urandom);
                    r.ftime = $urandom;
                    r.now = $urandom;
                    r.action = 2'($urandom_range(0, 2));
                end
            endcase
            pending_reqs.push_back(r);
            if (n == 35)
            begin
                // sender pause until every result is back
                wait_drained();
                write_timeout($urandom_range(0, 500));
            end
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS flow_table_with_aging");
        else
            $display("FAIL flow_table_with_aging");
        $finish;
    end

endmodule
